// ===== rtl/texture_rect_texel_fetch_blend_defines.svh =====
// Assertion macros shared by the checker of the texture fetch and blend block.
`ifndef TEXTURE_RECT_TEXEL_FETCH_BLEND_DEFINES_SVH
`define TEXTURE_RECT_TEXEL_FETCH_BLEND_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define TRTFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define TRTFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/trtfb_pkg.sv =====
// Types, constants and helper functions of the texture fetch and blend block.
`timescale 1ns / 1ps

package trtfb_pkg;

  // Operation codes carried by an input word.
  localparam logic [1:0] OP_WORD     = 2'd0;
  localparam logic [1:0] OP_PALETTE  = 2'd1;
  localparam logic [1:0] OP_PIXEL    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TEXEL_SIZE     = 3'd0;
  localparam logic [2:0] REG_TILE_BASE      = 3'd1;
  localparam logic [2:0] REG_LINE_WORDS     = 3'd2;
  localparam logic [2:0] REG_PALETTE_NUMBER = 3'd3;
  localparam logic [2:0] REG_S_START        = 3'd4;
  localparam logic [2:0] REG_T_START        = 3'd5;
  localparam logic [2:0] REG_STEP_S         = 3'd6;
  localparam logic [2:0] REG_STEP_T         = 3'd7;

  localparam int CFG_AW = 5;

  localparam int          PAL_BASE        = 'h100;
  localparam logic [4:0]  CHAN_MAX        = 5'h1F;
  localparam logic [3:0]  NO_BLEND_BANK   = 4'hD;
  localparam logic [15:0] STEP_ONE        = 16'd1024;
  localparam logic [5:0]  STEP_FORCED_INT = 6'd4;

  // Pixels that can be inside the block at once: five stages and the result register.
  localparam logic [3:0] PIPE_PIXELS = 4'd6;

  typedef struct packed {
    logic        texel_size;
    logic [8:0]  tile_base;
    logic [8:0]  line_words;
    logic [3:0]  palette_number;
    logic [15:0] s_start;
    logic [15:0] t_start;
    logic [15:0] step_s;
    logic [15:0] step_t;
  } cfg_t;

  // Saturating RGB add of RGBA 5-5-5-1 colours, alpha from texel; the texel if !blend_en.
  function automatic logic [15:0] blend_color(input logic [15:0] texel,
                                              input logic [15:0] old_c,
                                              input logic        blend_en);
    logic [5:0] b_sum;
    logic [5:0] g_sum;
    logic [5:0] r_sum;
    logic [4:0] b_sat;
    logic [4:0] g_sat;
    logic [4:0] r_sat;
    b_sum = {1'b0, texel[5:1]}   + {1'b0, old_c[5:1]};
    g_sum = {1'b0, texel[10:6]}  + {1'b0, old_c[10:6]};
    r_sum = {1'b0, texel[15:11]} + {1'b0, old_c[15:11]};
    b_sat = b_sum[5] ? CHAN_MAX : b_sum[4:0];
    g_sat = g_sum[5] ? CHAN_MAX : g_sum[4:0];
    r_sat = r_sum[5] ? CHAN_MAX : r_sum[4:0];
    return blend_en ? {r_sat, g_sat, b_sat, texel[0]} : texel;
  endfunction

endpackage

// ===== rtl/trtfb_stream_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface trtfb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [8:0]  mem_addr;
  logic [63:0] word_data;
  logic [15:0] old_color;
  logic        rect_start;
  logic        row_start;

  modport source (output valid, op, mem_addr, word_data, old_color, rect_start, row_start,
                  input ready);
  modport sink   (input valid, op, mem_addr, word_data, old_color, rect_start, row_start,
                  output ready);
endinterface

interface trtfb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

// ===== rtl/trtfb_cfg.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module trtfb_cfg import trtfb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.texel_size     <= 1'b0;
      cfg_r.tile_base      <= 9'd0;
      cfg_r.line_words     <= 9'd0;
      cfg_r.palette_number <= 4'd0;
      cfg_r.s_start        <= 16'd0;
      cfg_r.t_start        <= 16'd0;
      cfg_r.step_s         <= STEP_ONE;
      cfg_r.step_t         <= STEP_ONE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEXEL_SIZE:     cfg_r.texel_size     <= pwdata[0];
        REG_TILE_BASE:      cfg_r.tile_base      <= pwdata[8:0];
        REG_LINE_WORDS:     cfg_r.line_words     <= pwdata[8:0];
        REG_PALETTE_NUMBER: cfg_r.palette_number <= pwdata[3:0];
        REG_S_START:        cfg_r.s_start        <= pwdata[15:0];
        REG_T_START:        cfg_r.t_start        <= pwdata[15:0];
        REG_STEP_S:         cfg_r.step_s         <= pwdata[15:0];
        REG_STEP_T:         cfg_r.step_t         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEXEL_SIZE:     prdata = {31'd0, cfg_r.texel_size};
      REG_TILE_BASE:      prdata = {23'd0, cfg_r.tile_base};
      REG_LINE_WORDS:     prdata = {23'd0, cfg_r.line_words};
      REG_PALETTE_NUMBER: prdata = {28'd0, cfg_r.palette_number};
      REG_S_START:        prdata = {16'd0, cfg_r.s_start};
      REG_T_START:        prdata = {16'd0, cfg_r.t_start};
      REG_STEP_S:         prdata = {16'd0, cfg_r.step_s};
      REG_STEP_T:         prdata = {16'd0, cfg_r.step_t};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/trtfb_coord.sv =====
// Texture coordinate state: reload, per-row and per-pixel stepping, texel position.
`timescale 1ns / 1ps

module trtfb_coord import trtfb_pkg::*; #(
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          rect_start,
  input  logic          row_start,
  input  cfg_t          cfg,
  output logic [AW-1:0] word_off,
  output logic [3:0]    texel_sel,
  output logic [AW-1:0] row_y
);

  logic [31:0] coord_s_r;
  logic [31:0] coord_t_r;
  logic [31:0] coord_s_nxt;
  logic [31:0] coord_t_nxt;
  logic [31:0] cur_s;
  logic [31:0] s_start_x;
  logic [31:0] t_start_x;
  logic [31:0] step_s_x;
  logic [31:0] step_t_x;
  logic [15:0] step_s_eff;

  // Steps are 5.10 and coordinates 10.5, so a step adds its value shifted down by five.
  always_comb begin
    s_start_x  = {{16{cfg.s_start[15]}}, cfg.s_start};
    t_start_x  = {{16{cfg.t_start[15]}}, cfg.t_start};
    step_t_x   = {{21{cfg.step_t[15]}}, cfg.step_t[15:5]};
    // A horizontal step with integer part four is taken as one.
    step_s_eff = (cfg.step_s[15:10] == STEP_FORCED_INT) ? STEP_ONE : cfg.step_s;
    step_s_x   = {{21{step_s_eff[15]}}, step_s_eff[15:5]};

    if (rect_start) begin
      coord_t_nxt = t_start_x;
    end else if (row_start) begin
      coord_t_nxt = coord_t_r + step_t_x;
    end else begin
      coord_t_nxt = coord_t_r;
    end
    cur_s       = (rect_start || row_start) ? s_start_x : coord_s_r;
    coord_s_nxt = cur_s + step_s_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_s_r <= 32'd0;
      coord_t_r <= 32'd0;
    end else if (step_en) begin
      coord_s_r <= coord_s_nxt;
      coord_t_r <= coord_t_nxt;
    end
  end

  // Only the low address bits matter since the memory address wraps.
  assign word_off  = cfg.texel_size ? cur_s[8 +: AW] : cur_s[9 +: AW];
  assign texel_sel = cfg.texel_size ? {1'b0, cur_s[7:5]} : cur_s[8:5];
  assign row_y     = coord_t_nxt[5 +: AW];

endmodule

// ===== rtl/trtfb_tmem.sv =====
// Texture memory: one write port, two registered read ports with write forwarding on the first.
`timescale 1ns / 1ps

module trtfb_tmem #(
  parameter int MEM_WORDS = 512,
  localparam int AW = $clog2(MEM_WORDS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          rd1_en,
  input  logic [AW-1:0] raddr1,
  output logic [63:0]   rdata1,
  input  logic          rd2_en,
  input  logic [AW-1:0] raddr2,
  output logic [63:0]   rdata2
);

  logic [63:0] mem_r [MEM_WORDS];
  logic [63:0] rdata1_r;
  logic [63:0] rdata2_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // A write landing in the same edge as a read on port one is passed straight through.
  always_ff @(posedge clk) begin
    if (rd1_en) begin
      rdata1_r <= (we && (waddr == raddr1)) ? wdata : mem_r[raddr1];
    end
  end

  always_ff @(posedge clk) begin
    if (rd2_en) begin
      rdata2_r <= mem_r[raddr2];
    end
  end

  assign rdata1 = rdata1_r;
  assign rdata2 = rdata2_r;

endmodule

// ===== rtl/texture_rect_texel_fetch_blend.sv =====
// Top level of the colour-indexed texture fetch and additive blend pipeline.
`timescale 1ns / 1ps

// Colour-indexed texture fetch with palette lookup and additive blend. The block takes one
// input word per clock and gives one result word per clock when the result side keeps up;
// an accepted pixel word passes stages 1 to 5 on its way to the result register, and memory
// writes give no result. The rate is set by the texture memory, which has one write port
// and two read ports (texel index word and palette word), each used once per word. Input
// words are: a 64-bit memory word write, a palette-entry write that repeats the low 16 bits
// of the data into all four lanes, or a pixel. A pixel steps the 10.5 fixed point texture
// coordinates (start reload on the first pixel of a rectangle, row step and horizontal
// reload on the first pixel of a later row), fetches a 4- or 8-bit index from the tile,
// reads the palette entry from the top lane of a word in the palette area at word 0x100,
// and adds it to the old frame buffer colour with each 5-bit channel saturating, unless
// palette number 13 is selected, in which case the entry is the result. MEM_WORDS must be
// a power of two between 256 and 4096; all texture memory addresses wrap at that depth.
// The memory has no reset and no clearing pass: a pixel that reads a word never written
// gets an undefined colour. Configuration registers may be written only while the block
// holds no word in flight.

module texture_rect_texel_fetch_blend import trtfb_pkg::*; #(
  parameter int MEM_WORDS = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  trtfb_in_if.sink           in_ch,
  trtfb_out_if.source        out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MEM_WORDS);

  cfg_t cfg;

  // Stage advance terms: a stage loads when it is empty or its word moves on.
  logic adv1;
  logic adv2;
  logic adv3;
  logic adv4;
  logic adv5;
  logic adv_out;

  logic in_acc;
  logic pix_acc;

  logic [AW-1:0] word_off;
  logic [3:0]    texel_sel;
  logic [AW-1:0] row_y;

  // Stage 1: coordinates resolved for this word.
  logic          v1_r;
  logic [1:0]    op1_r;
  logic [AW-1:0] waddr1_r;
  logic [63:0]   wdata1_r;
  logic [15:0]   old1_r;
  logic [AW-1:0] woff1_r;
  logic [3:0]    sel1_r;
  logic [AW-1:0] rowy1_r;

  // Stage 2: row offset product.
  logic          v2_r;
  logic [1:0]    op2_r;
  logic [AW-1:0] waddr2_r;
  logic [63:0]   wdata2_r;
  logic [15:0]   old2_r;
  logic [AW-1:0] woff2_r;
  logic [3:0]    sel2_r;
  logic [AW-1:0] prod2_r;
  logic [AW+8:0] prod_full;

  // Stage 3: index word address, presented to the first read port.
  logic          v3_r;
  logic [1:0]    op3_r;
  logic [AW-1:0] waddr3_r;
  logic [63:0]   wdata3_r;
  logic [15:0]   old3_r;
  logic [3:0]    sel3_r;
  logic [AW-1:0] raddr3_r;
  logic [AW-1:0] raddr_nxt;

  // Stage 4: index word back from memory; palette read and memory writes issue here.
  logic          v4_r;
  logic [1:0]    op4_r;
  logic [AW-1:0] waddr4_r;
  logic [63:0]   wdata4_r;
  logic [15:0]   old4_r;
  logic [3:0]    sel4_r;
  logic [63:0]   idx_word;
  logic [5:0]    idx_shift;
  logic [63:0]   idx_shifted;
  logic [AW-1:0] pal_addr;
  logic          mem_we;

  // Stage 5: palette word back from memory.
  logic          v5_r;
  logic [15:0]   old5_r;
  logic [63:0]   pal_word;

  // Result register.
  logic          out_v_r;
  logic [15:0]   out_color_r;

  assign adv_out = !out_v_r || out_ch.ready;
  assign adv5    = !v5_r || adv_out;
  assign adv4    = !v4_r || adv5;
  assign adv3    = !v3_r || adv4;
  assign adv2    = !v2_r || adv3;
  assign adv1    = !v1_r || adv2;

  assign in_ch.ready = adv1;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign pix_acc     = in_acc && (in_ch.op == OP_PIXEL);

  trtfb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Coordinates change at acceptance, so words keep their order through the pipeline.
  trtfb_coord #(
    .AW (AW)
  ) u_coord (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (pix_acc),
    .rect_start (in_ch.rect_start),
    .row_start  (in_ch.row_start),
    .cfg        (cfg),
    .word_off   (word_off),
    .texel_sel  (texel_sel),
    .row_y      (row_y)
  );

  // Stage valid bits. The reserved operation is accepted and dropped at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_acc && (in_ch.op != OP_RESERVED);
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
      // Writes retire out of stage 4; only pixels go on.
      if (adv5) begin
        v5_r <= v4_r && (op4_r == OP_PIXEL);
      end
      if (adv_out) begin
        out_v_r <= v5_r;
      end
    end
  end

  assign prod_full = rowy1_r * cfg.line_words;
  assign raddr_nxt = AW'(cfg.tile_base) + prod2_r + woff2_r;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv1) begin
      op1_r    <= in_ch.op;
      waddr1_r <= AW'(in_ch.mem_addr);
      wdata1_r <= (in_ch.op == OP_PALETTE) ? {4{in_ch.word_data[15:0]}} : in_ch.word_data;
      old1_r   <= in_ch.old_color;
      woff1_r  <= word_off;
      sel1_r   <= texel_sel;
      rowy1_r  <= row_y;
    end
    if (adv2) begin
      op2_r    <= op1_r;
      waddr2_r <= waddr1_r;
      wdata2_r <= wdata1_r;
      old2_r   <= old1_r;
      woff2_r  <= woff1_r;
      sel2_r   <= sel1_r;
      prod2_r  <= prod_full[AW-1:0];
    end
    if (adv3) begin
      op3_r    <= op2_r;
      waddr3_r <= waddr2_r;
      wdata3_r <= wdata2_r;
      old3_r   <= old2_r;
      sel3_r   <= sel2_r;
      raddr3_r <= raddr_nxt;
    end
    if (adv4) begin
      op4_r    <= op3_r;
      waddr4_r <= waddr3_r;
      wdata4_r <= wdata3_r;
      old4_r   <= old3_r;
      sel4_r   <= sel3_r;
    end
    if (adv5) begin
      old5_r <= old4_r;
    end
    if (adv_out) begin
      out_color_r <= blend_color(pal_word[63:48], old5_r,
                                 cfg.palette_number != NO_BLEND_BANK);
    end
  end

  // Texels are packed most significant first within a word.
  always_comb begin
    if (cfg.texel_size) begin
      idx_shift = {~sel4_r[2:0], 3'b000};
    end else begin
      idx_shift = {~sel4_r, 2'b00};
    end
    idx_shifted = idx_word >> idx_shift;
    if (cfg.texel_size) begin
      pal_addr = AW'(PAL_BASE) + AW'(idx_shifted[7:0]);
    end else begin
      pal_addr = AW'(PAL_BASE) + AW'({cfg.palette_number, idx_shifted[3:0]});
    end
  end

  // Writes land as they leave stage 4. A younger pixel reading the index word at that very
  // edge gets the new data forwarded; older pixels have already done both of their reads.
  assign mem_we = v4_r && adv5 && ((op4_r == OP_WORD) || (op4_r == OP_PALETTE));

  trtfb_tmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_tmem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (waddr4_r),
    .wdata  (wdata4_r),
    .rd1_en (adv4),
    .raddr1 (raddr3_r),
    .rdata1 (idx_word),
    .rd2_en (adv5),
    .raddr2 (pal_addr),
    .rdata2 (pal_word)
  );

  assign out_ch.valid       = out_v_r;
  assign out_ch.pixel_color = out_color_r;

endmodule

// ===== rtl/trtfb_chk.sv =====
// Port-level checker for the texture fetch and blend block, bound to the top level.
`timescale 1ns / 1ps
`include "texture_rect_texel_fetch_blend_defines.svh"

module trtfb_chk import trtfb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel_color
);

  logic       pix_in;
  logic       word_out;
  logic [3:0] pend_r;
  logic [3:0] pend_nxt;

  assign pix_in   = in_valid && in_ready && (in_op == OP_PIXEL);
  assign word_out = out_valid && out_ready;

  // Pixels accepted whose result has not yet been taken.
  always_comb begin
    case ({pix_in, word_out})
      2'b10:   pend_nxt = pend_r + 4'd1;
      2'b01:   pend_nxt = pend_r - 4'd1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `TRTFB_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready,
                    "input not ready although no result word is waiting")
  `TRTFB_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
                     out_valid && $stable(out_pixel_color), "stalled result word changed")
  `TRTFB_ASSERT_NOW(a_no_spurious_result, word_out, pend_r != 4'd0,
                    "result word without an outstanding pixel")
  `TRTFB_ASSERT_NOW(a_bounded_pending, 1'b1, pend_r <= PIPE_PIXELS,
                    "more pixels in flight than the pipeline holds")

endmodule

bind texture_rect_texel_fetch_blend trtfb_chk u_trtfb_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_op           (in_ch.op),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_color (out_ch.pixel_color)
);

// ===== tb/sv/texture_rect_texel_fetch_blend_checker.sv =====
// Checker that predicts and compares the pixel colours of the texture fetch and blend block.
`timescale 1ns / 1ps

module texture_rect_texel_fetch_blend_checker import trtfb_pkg::*; #(
  parameter int MEM_WORDS = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  trtfb_in_if               in_mon,
  trtfb_out_if              out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [63:0] tex_words [MEM_WORDS];
  cfg_t        regs;
  logic [31:0] cur_s;
  logic [31:0] cur_t;
  logic [15:0] colour_q [$];

  // One step of a 10.5 coordinate by a 5.10 delta, rounded towards minus infinity.
  function automatic logic [31:0] advance(input logic [31:0] c, input logic [15:0] d);
    logic signed [63:0] acc;
    logic signed [63:0] inc;
    acc = 64'($signed(c));
    inc = 64'($signed(d));
    acc = ((acc <<< 5) + inc) >>> 5;
    return acc[31:0];
  endfunction

  task automatic shade_pixel(input logic [15:0] old_c, input logic rect, input logic row,
                             output logic [15:0] colour);
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [63:0] row_base;
    logic signed [63:0] waddr;
    logic [63:0]        word;
    logic [7:0]         idx;
    logic [AW-1:0]      pal;
    logic [15:0]        entry;
    logic [5:0]         r;
    logic [5:0]         g;
    logic [5:0]         b;
    logic [15:0]        ds;
    if (rect) begin
      cur_s = {{16{regs.s_start[15]}}, regs.s_start};
      cur_t = {{16{regs.t_start[15]}}, regs.t_start};
    end else if (row) begin
      cur_t = advance(cur_t, regs.step_t);
      cur_s = {{16{regs.s_start[15]}}, regs.s_start};
    end
    x = $signed(cur_s) >>> 5;
    y = $signed(cur_t) >>> 5;
    row_base = 64'($signed({1'b0, regs.tile_base}))
             + 64'($signed({1'b0, regs.line_words})) * 64'(y);
    if (!regs.texel_size) begin
      waddr = row_base + 64'(x >>> 4);
      word  = tex_words[waddr[AW-1:0]] >> (60 - 4 * x[3:0]);
      idx   = {4'h0, word[3:0]};
      pal   = AW'(PAL_BASE + 16 * regs.palette_number + idx);
    end else begin
      waddr = row_base + 64'(x >>> 3);
      word  = tex_words[waddr[AW-1:0]] >> (56 - 8 * x[2:0]);
      idx   = word[7:0];
      pal   = AW'(PAL_BASE + idx);
    end
    entry = tex_words[pal][63:48];
    if (regs.palette_number != NO_BLEND_BANK) begin
      b = {1'b0, entry[5:1]} + {1'b0, old_c[5:1]};
      g = {1'b0, entry[10:6]} + {1'b0, old_c[10:6]};
      r = {1'b0, entry[15:11]} + {1'b0, old_c[15:11]};
      if (b > {1'b0, CHAN_MAX}) b = {1'b0, CHAN_MAX};
      if (g > {1'b0, CHAN_MAX}) g = {1'b0, CHAN_MAX};
      if (r > {1'b0, CHAN_MAX}) r = {1'b0, CHAN_MAX};
      colour = {r[4:0], g[4:0], b[4:0], entry[0]};
    end else begin
      colour = entry;
    end
    // A horizontal step of 4.x is taken as exactly 1.0.
    ds = (regs.step_s[15:10] == STEP_FORCED_INT) ? STEP_ONE : regs.step_s;
    cur_s = advance(cur_s, ds);
  endtask

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      regs        = '0;
      regs.step_s = STEP_ONE;
      regs.step_t = STEP_ONE;
      cur_s       = '0;
      cur_t       = '0;
      colour_q.delete();
      fail_count  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_AW-1:2])
          REG_TEXEL_SIZE:     regs.texel_size     = pwdata[0];
          REG_TILE_BASE:      regs.tile_base      = pwdata[8:0];
          REG_LINE_WORDS:     regs.line_words     = pwdata[8:0];
          REG_PALETTE_NUMBER: regs.palette_number = pwdata[3:0];
          REG_S_START:        regs.s_start        = pwdata[15:0];
          REG_T_START:        regs.t_start        = pwdata[15:0];
          REG_STEP_S:         regs.step_s         = pwdata[15:0];
          REG_STEP_T:         regs.step_t         = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_WORD:    tex_words[in_mon.mem_addr[AW-1:0]] = in_mon.word_data;
          OP_PALETTE: tex_words[in_mon.mem_addr[AW-1:0]] = {4{in_mon.word_data[15:0]}};
          OP_PIXEL: begin
            shade_pixel(in_mon.old_color, in_mon.rect_start, in_mon.row_start, want);
            colour_q.push_back(want);
          end
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (colour_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word %h with no pixel waiting", $time, out_mon.pixel_color);
          fail_count++;
        end else begin
          want = colour_q.pop_front();
          if (out_mon.pixel_color !== want) begin
            if (fail_count < 10)
              $display("%0t: pixel colour expected %h, got %h", $time, want,
                       out_mon.pixel_color);
            fail_count++;
          end
        end
      end
    end
    pending = colour_q.size();
  end

endmodule

// ===== tb/sv/texture_rect_texel_fetch_blend_test.sv =====
// Top of the testbench: clock, reset, stimulus, register set-up and verdict.
`timescale 1ns / 1ps

module texture_rect_texel_fetch_blend_test import trtfb_pkg::*;;

  localparam int MEM_WORDS  = 512;
  localparam int CYCLE_CAP  = 300000;
  localparam int LONG_HOLD  = 150;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  // Bookkeeping for the sender's bursts and for the long stalls asked of the receiver.
  int burst_left;
  int hold_asks;
  int holds_done;
  int cycles;

  trtfb_in_if  in_ch ();
  trtfb_out_if out_ch ();

  texture_rect_texel_fetch_blend #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The checker sees every accepted word and every register write, keeps its own copy of
  // the texture memory and coordinates, and reports how many results went wrong.
  texture_rect_texel_fetch_blend_checker #(.MEM_WORDS(MEM_WORDS)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("texture_rect_texel_fetch_blend test failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one word and returns at the falling edge after it has been taken. Between bursts
  // the sender drops valid for a random gap, sometimes none at all.
  task automatic offer_word(input logic [1:0] op, input logic [8:0] addr,
                            input logic [63:0] data, input logic [15:0] old_c,
                            input logic rect, input logic row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        in_ch.valid = 1'b0;
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.op         = op;
    in_ch.mem_addr   = addr;
    in_ch.word_data  = data;
    in_ch.old_color  = old_c;
    in_ch.rect_start = rect;
    in_ch.row_start  = row;
    in_ch.valid      = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic offer_pixel(input logic [15:0] old_c, input logic rect, input logic row);
    offer_word(OP_PIXEL, 9'($urandom), rand_word(), old_c, rect, row);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Registers may only change with nothing in flight. Once the last colour is back, a memory
  // write can still be in the pipeline, so the bench lets that drain too before the writes.
  task automatic load_setup(input cfg_t s);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_PIXELS + 2) @(negedge clk);
    reg_write(REG_TEXEL_SIZE, 32'(s.texel_size));
    reg_write(REG_TILE_BASE, 32'(s.tile_base));
    reg_write(REG_LINE_WORDS, 32'(s.line_words));
    reg_write(REG_PALETTE_NUMBER, 32'(s.palette_number));
    reg_write(REG_S_START, 32'(s.s_start));
    reg_write(REG_T_START, 32'(s.t_start));
    reg_write(REG_STEP_S, 32'(s.step_s));
    reg_write(REG_STEP_T, 32'(s.step_t));
  endtask

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1:       return 16'd4096 + 16'($urandom_range(0, 1023));
      2:       return 16'($urandom_range(0, 2047));
      3:       return -16'($urandom_range(1, 2047));
      default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic cfg_t random_setup();
    cfg_t s;
    s.texel_size     = 1'($urandom);
    s.tile_base      = 9'($urandom);
    case ($urandom_range(0, 3))
      0:       s.line_words = 9'd0;
      1:       s.line_words = 9'd511;
      default: s.line_words = 9'($urandom_range(1, 40));
    endcase
    s.palette_number = ($urandom_range(0, 2) == 0) ? NO_BLEND_BANK : 4'($urandom);
    s.s_start        = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
    s.t_start        = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
    s.step_s         = pick_step();
    s.step_t         = pick_step();
    return s;
  endfunction

  // Receiver: segments of steady, random, mostly high or sparse ready, with a long hold-off
  // whenever the stimulus asks for one, so the pipeline fills and back-pressure reaches the input.
  initial begin
    int mode;
    int len;
    out_ch.ready = 1'b0;
    holds_done   = 0;
    @(negedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 80);
        repeat (len) begin
          case (mode)
            0:       out_ch.ready = 1'b1;
            1:       out_ch.ready = 1'($urandom);
            2:       out_ch.ready = ($urandom_range(0, 3) != 0);
            default: out_ch.ready = ($urandom_range(0, 4) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    cfg_t s;
    int   sent;
    int   kind;
    int   rows;
    int   cols;
    int   waited;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_WORD;
    in_ch.mem_addr   = '0;
    in_ch.word_data  = '0;
    in_ch.old_color  = '0;
    in_ch.rect_start = 1'b0;
    in_ch.row_start  = 1'b0;
    burst_left       = 0;
    hold_asks        = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Every word of the texture memory is written first, so no pixel ever reads a word that
    // holds nothing defined, wherever its coordinates wrap to.
    for (int a = 0; a < MEM_WORDS; a++)
      offer_word(($urandom_range(0, 1) != 0) ? OP_PALETTE : OP_WORD, 9'(a), rand_word(),
                 16'($urandom), 1'($urandom), 1'($urandom));

    // Directed part, first with the settings left by reset: 4-bit texels, palette 0, blend.
    offer_pixel(16'h0000, 1'b1, 1'b0);
    offer_pixel(16'hFFFF, 1'b0, 1'b0);
    offer_pixel(16'($urandom), 1'b0, 1'b1);
    offer_pixel(16'h8421, 1'b1, 1'b1);
    // The reserved operation must change nothing, not even the coordinates.
    offer_word(OP_RESERVED, 9'h1FF, '1, 16'hFFFF, 1'b1, 1'b1);
    offer_word(OP_RESERVED, 9'h000, '0, 16'h0000, 1'b0, 1'b0);
    offer_pixel(16'h7BDE, 1'b0, 1'b0);
    offer_word(OP_WORD, 9'h1FF, '1, 16'h0000, 1'b0, 1'b0);
    offer_word(OP_WORD, 9'h000, '0, 16'hFFFF, 1'b1, 1'b1);
    offer_word(OP_PALETTE, 9'h100, {48'h0, 16'hFFFF}, 16'h0, 1'b0, 1'b0);
    offer_word(OP_PALETTE, 9'h1FF, {48'hFFFF_FFFF_FFFF, 16'h0000}, 16'h0, 1'b0, 1'b0);
    offer_pixel(16'hFFFF, 1'b1, 1'b0);

    // Extremes: 8-bit texels, top of memory, no blend, a step of exactly 4.0 taken as 1.0,
    // and the most negative row step.
    s = '{texel_size: 1'b1, tile_base: 9'd511, line_words: 9'd511,
          palette_number: NO_BLEND_BANK, s_start: 16'h8000, t_start: 16'h7FFF,
          step_s: 16'h1000, step_t: 16'h8000};
    load_setup(s);
    offer_pixel(16'h0000, 1'b1, 1'b0);
    offer_pixel(16'hFFFF, 1'b0, 1'b0);
    offer_pixel(16'h5555, 1'b0, 1'b0);
    offer_pixel(16'hAAAA, 1'b0, 1'b1);
    offer_pixel(16'h1234, 1'b0, 1'b0);

    // Other end: bank 15 with blend, the top of the forced 4.x step range, largest row step.
    s = '{texel_size: 1'b0, tile_base: 9'd0, line_words: 9'd1, palette_number: 4'hF,
          s_start: 16'h7FFF, t_start: 16'h8000, step_s: 16'h13FF, step_t: 16'h7FFF};
    load_setup(s);
    offer_pixel(16'hFFFF, 1'b1, 1'b0);
    offer_pixel(16'h0001, 1'b0, 1'b0);
    offer_pixel(16'hF800, 1'b0, 1'b1);
    offer_pixel(16'h07C0, 1'b0, 1'b0);

    // Random part: mostly whole rectangles of rows of pixels, with memory writes, stray
    // pixels with arbitrary flags and reserved words mixed in.
    for (int ph = 0; ph < 12; ph++) begin
      load_setup(random_setup());
      if (ph == 1 || ph == 7) hold_asks++;
      sent = 0;
      while (sent < 95) begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          offer_word(($urandom_range(0, 1) != 0) ? OP_PALETTE : OP_WORD, 9'($urandom),
                     rand_word(), 16'($urandom), 1'($urandom), 1'($urandom));
          sent++;
        end else if (kind < 12) begin
          offer_word(OP_RESERVED, 9'($urandom), rand_word(), 16'($urandom), 1'($urandom),
                     1'($urandom));
        end else if (kind < 17) begin
          offer_pixel(16'($urandom), 1'($urandom), 1'($urandom));
          sent++;
        end else begin
          rows = $urandom_range(1, 5);
          for (int r = 0; r < rows; r++) begin
            cols = $urandom_range(1, 10);
            for (int c = 0; c < cols; c++) begin
              offer_pixel(16'($urandom), (r == 0 && c == 0), (r != 0 && c == 0));
              sent++;
            end
          end
        end
      end
    end

    // Let the last colours drain and the pipeline empty, then give the verdict.
    in_ch.valid = 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4 * PIPE_PIXELS) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("texture_rect_texel_fetch_blend test passed");
    end else begin
      $display("texture_rect_texel_fetch_blend test failed");
    end
    $finish;
  end

endmodule

// ===== texture_rect_texel_fetch_blend.f =====
+incdir+rtl
rtl/trtfb_pkg.sv
rtl/trtfb_stream_if.sv
rtl/trtfb_cfg.sv
rtl/trtfb_coord.sv
rtl/trtfb_tmem.sv
rtl/texture_rect_texel_fetch_blend.sv
rtl/trtfb_chk.sv
tb/sv/texture_rect_texel_fetch_blend_checker.sv
tb/sv/texture_rect_texel_fetch_blend_test.sv
